// ----- sv/gclt_pkg.sv -----
// ----------------------------------------------------------------------------
// Glyph cache LRU table package
// Shared widths, codes, state and struct types for the glyph cache table.
// ----------------------------------------------------------------------------
`default_nettype none

package gclt_pkg;

   localparam int CACHE_ENTRIES_DEF = 64;
   localparam int STAMP_BITS_DEF    = 32;

   localparam int ACTION_W = 2;
   localparam int CP_W     = 21;
   localparam int PX_W     = 8;
   localparam int FS_W     = 4;
   localparam int TINT_W   = 16;
   localparam int HANDLE_W = 16;
   localparam int KEY_W    = CP_W + PX_W + FS_W + TINT_W;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOOKUP = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_KEY,
      ST_SCAN_AGE,
      ST_READ_LAST,
      ST_MOVE,
      ST_APPEND,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [CP_W-1:0]   code_point;
      logic [PX_W-1:0]   pixel_size;
      logic [FS_W-1:0]   font_slot;
      logic [TINT_W-1:0] tint_color;
   } key_type;

   typedef struct packed {
      logic valid;
      logic first;
   } scan_ctl_type;

endpackage

`default_nettype wire

// ----- sv/gclt_req_if.sv -----
// ----------------------------------------------------------------------------
// Glyph cache request channel
// Valid/ready channel carrying one action word with its key and handle.
// ----------------------------------------------------------------------------
`default_nettype none

interface gclt_req_if;
   import gclt_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [CP_W-1:0]     code_point;
   logic [PX_W-1:0]     pixel_size;
   logic [FS_W-1:0]     font_slot;
   logic [TINT_W-1:0]   tint_color;
   logic [HANDLE_W-1:0] bitmap_handle;

   modport source (
      output valid, action, code_point, pixel_size, font_slot, tint_color, bitmap_handle,
      input  ready
   );

   modport sink (
      input  valid, action, code_point, pixel_size, font_slot, tint_color, bitmap_handle,
      output ready
   );

endinterface

`default_nettype wire

// ----- sv/gclt_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Glyph cache response channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface gclt_rsp_if #(
   parameter int OCC_W = 7
);
   import gclt_pkg::*;

   logic                valid;
   logic                ready;
   logic                hit;
   logic [HANDLE_W-1:0] found_handle;
   logic                evicted;
   logic [HANDLE_W-1:0] evicted_handle;
   logic [OCC_W-1:0]    occupancy;

   modport source (
      output valid, hit, found_handle, evicted, evicted_handle, occupancy,
      input  ready
   );

   modport sink (
      input  valid, hit, found_handle, evicted, evicted_handle, occupancy,
      output ready
   );

endinterface

`default_nettype wire

// ----- sv/gclt_entry_ram.sv -----
// ----------------------------------------------------------------------------
// Glyph cache entry memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gclt_entry_ram #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 97,
   parameter int IDX_W  = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- sv/gclt_cmp_unit.sv -----
// ----------------------------------------------------------------------------
// Glyph cache compare unit
// Key match against the request and running oldest-stamp search over the
// entry words streaming out of the memory.
// ----------------------------------------------------------------------------
`default_nettype none

module gclt_cmp_unit #(
   parameter int STAMP_BITS = 32,
   parameter int IDX_W      = 6
) (
   input  logic                          clock,
   input  gclt_pkg::scan_ctl_type        ctl,
   input  gclt_pkg::key_type             req_key,
   input  gclt_pkg::key_type             rd_key,
   input  logic [STAMP_BITS-1:0]         rd_stamp,
   input  logic [gclt_pkg::HANDLE_W-1:0] rd_handle,
   input  logic [IDX_W-1:0]              rd_idx,
   output logic                          key_eq,
   output logic [IDX_W-1:0]              best_idx,
   output logic [gclt_pkg::HANDLE_W-1:0] best_handle
);
   import gclt_pkg::*;

   logic [STAMP_BITS-1:0] best_stamp_ff, best_stamp_in;
   logic [IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [HANDLE_W-1:0]   best_handle_ff, best_handle_in;
   logic                  older;

   assign key_eq = (rd_key == req_key);
   // strict compare keeps the lowest index on equal stamps
   assign older  = (rd_stamp < best_stamp_ff);

   always_comb begin
      best_stamp_in  = best_stamp_ff;
      best_idx_in    = best_idx_ff;
      best_handle_in = best_handle_ff;
      if (ctl.valid && (ctl.first || older)) begin
         best_stamp_in  = rd_stamp;
         best_idx_in    = rd_idx;
         best_handle_in = rd_handle;
      end
   end

   always_ff @(posedge clock) begin
      best_stamp_ff  <= best_stamp_in;
      best_idx_ff    <= best_idx_in;
      best_handle_ff <= best_handle_in;
   end

   assign best_idx    = best_idx_ff;
   assign best_handle = best_handle_ff;

endmodule

`default_nettype wire

// ----- sv/glyph_cache_lru_table_unit.sv -----
// ----------------------------------------------------------------------------
// Glyph cache LRU table
// Fully associative table of glyph handles keyed by code point, size, font
// slot and tint, with least-recently-used replacement by use stamp.
//
// req_ch takes one word at a time: lookup, insert, clear or no-op. rsp_ch
// returns exactly one word per request. A request is taken only in idle;
// the block then works on it alone, one table entry per cycle through the
// single memory read port and the shared compare unit:
//   lookup : key scan from index 0, ending at the first match or the last entry
//   insert : append below full; on a full table an age scan, a read of the
//            last entry, a move into the freed slot and an append
//   clear, no-op, lookup on an empty table : straight to the result state
// A finished result sits in the output register; the next request is taken
// while it waits, and a completed request holds in its result state until
// the output register frees up. Reset empties the table, zeroes the use
// tick and drops any pending result; memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_cache_lru_table_unit #(
   parameter int CACHE_ENTRIES = gclt_pkg::CACHE_ENTRIES_DEF,
   parameter int STAMP_BITS    = gclt_pkg::STAMP_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   gclt_req_if.sink  req_ch,
   gclt_rsp_if.source rsp_ch
);
   import gclt_pkg::*;

   localparam int IDX_W  = $clog2(CACHE_ENTRIES);
   localparam int OCC_W  = $clog2(CACHE_ENTRIES + 1);
   localparam int DATA_W = KEY_W + HANDLE_W + STAMP_BITS;
   localparam logic [OCC_W-1:0] FULL_COUNT = OCC_W'(CACHE_ENTRIES);

   state_type             state_ff, state_in;
   logic [OCC_W-1:0]      count_ff, count_in;
   logic [STAMP_BITS-1:0] tick_ff, tick_in;
   key_type               key_ff, key_in;
   logic [HANDLE_W-1:0]   handle_ff, handle_in;
   logic [OCC_W-1:0]      addr_ff, addr_in;
   logic                  pend_ff, pend_in;
   logic [IDX_W-1:0]      pend_idx_ff, pend_idx_in;

   logic                  res_hit_ff, res_hit_in;
   logic [HANDLE_W-1:0]   res_found_ff, res_found_in;
   logic                  res_ev_ff, res_ev_in;
   logic [HANDLE_W-1:0]   res_ev_handle_ff, res_ev_handle_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [HANDLE_W-1:0]   rsp_found_ff, rsp_found_in;
   logic                  rsp_ev_ff, rsp_ev_in;
   logic [HANDLE_W-1:0]   rsp_ev_handle_ff, rsp_ev_handle_in;
   logic [OCC_W-1:0]      rsp_occ_ff, rsp_occ_in;

   logic                  req_fire;
   logic                  rsp_free;
   action_type            req_action;
   logic [OCC_W-1:0]      last_idx;
   logic                  pend_last;
   logic                  scanning;
   logic                  issue;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [DATA_W-1:0]     wr_data;
   logic [IDX_W-1:0]      rd_addr;
   logic [DATA_W-1:0]     rd_data;
   key_type               rd_key;
   logic [HANDLE_W-1:0]   rd_handle;
   logic [STAMP_BITS-1:0] rd_stamp;
   scan_ctl_type          scan_ctl;
   logic                  key_eq;
   logic [IDX_W-1:0]      best_idx;
   logic [HANDLE_W-1:0]   best_handle;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign req_action   = action_type'(req_ch.action);
   assign rsp_free     = ~rsp_valid_ff | rsp_ch.ready;

   assign last_idx  = count_ff - 1'b1;
   assign pend_last = (OCC_W'(pend_idx_ff) == last_idx);
   assign scanning  = (state_ff == ST_SCAN_KEY) || (state_ff == ST_SCAN_AGE);
   assign issue     = scanning && (addr_ff < count_ff);
   assign rd_addr   = (state_ff == ST_READ_LAST) ? last_idx[IDX_W-1:0] : addr_ff[IDX_W-1:0];

   assign rd_key    = key_type'(rd_data[DATA_W-1 -: KEY_W]);
   assign rd_handle = rd_data[STAMP_BITS +: HANDLE_W];
   assign rd_stamp  = rd_data[STAMP_BITS-1:0];

   assign scan_ctl.valid = (state_ff == ST_SCAN_AGE) && pend_ff;
   assign scan_ctl.first = (pend_idx_ff == '0);

   gclt_entry_ram #(
      .DEPTH  (CACHE_ENTRIES),
      .DATA_W (DATA_W),
      .IDX_W  (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gclt_cmp_unit #(
      .STAMP_BITS (STAMP_BITS),
      .IDX_W      (IDX_W)
   ) u_cmp (
      .clock       (clock),
      .ctl         (scan_ctl),
      .req_key     (key_ff),
      .rd_key      (rd_key),
      .rd_stamp    (rd_stamp),
      .rd_handle   (rd_handle),
      .rd_idx      (pend_idx_ff),
      .key_eq      (key_eq),
      .best_idx    (best_idx),
      .best_handle (best_handle)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_action)
                  ACT_LOOKUP: state_in = (count_ff == '0) ? ST_RESP : ST_SCAN_KEY;
                  ACT_INSERT: state_in = (count_ff >= FULL_COUNT) ? ST_SCAN_AGE : ST_APPEND;
                  default:    state_in = ST_RESP;
               endcase
            end
         end
         ST_SCAN_KEY: begin
            if (pend_ff && (key_eq || pend_last)) begin
               state_in = ST_RESP;
            end
         end
         ST_SCAN_AGE: begin
            if (pend_ff && pend_last) begin
               state_in = ST_READ_LAST;
            end
         end
         ST_READ_LAST: state_in = ST_MOVE;
         ST_MOVE:      state_in = ST_APPEND;
         ST_APPEND:    state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in         = count_ff;
      tick_in          = tick_ff;
      key_in           = key_ff;
      handle_in        = handle_ff;
      addr_in          = addr_ff;
      pend_in          = 1'b0;
      pend_idx_in      = rd_addr;
      res_hit_in       = res_hit_ff;
      res_found_in     = res_found_ff;
      res_ev_in        = res_ev_ff;
      res_ev_handle_in = res_ev_handle_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_ch.ready;
      rsp_hit_in       = rsp_hit_ff;
      rsp_found_in     = rsp_found_ff;
      rsp_ev_in        = rsp_ev_ff;
      rsp_ev_handle_in = rsp_ev_handle_ff;
      rsp_occ_in       = rsp_occ_ff;
      wr_en            = 1'b0;
      wr_addr          = pend_idx_ff;
      wr_data          = {rd_key, rd_handle, tick_ff};

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               key_in.code_point = req_ch.code_point;
               key_in.pixel_size = req_ch.pixel_size;
               key_in.font_slot  = req_ch.font_slot;
               key_in.tint_color = req_ch.tint_color;
               handle_in         = req_ch.bitmap_handle;
               addr_in           = '0;
               res_hit_in        = 1'b0;
               res_found_in      = '0;
               res_ev_in         = 1'b0;
               res_ev_handle_in  = '0;
               if (req_action == ACT_CLEAR) begin
                  count_in = '0;
               end
            end
         end
         ST_SCAN_KEY, ST_SCAN_AGE: begin
            pend_in = issue;
            if (issue) begin
               addr_in = addr_ff + 1'b1;
            end
            // restamp the first matching entry
            if ((state_ff == ST_SCAN_KEY) && pend_ff && key_eq) begin
               wr_en        = 1'b1;
               tick_in      = tick_ff + 1'b1;
               res_hit_in   = 1'b1;
               res_found_in = rd_handle;
            end
         end
         ST_READ_LAST: begin
            pend_in = 1'b1;
         end
         ST_MOVE: begin
            // last entry fills the slot of the evicted one
            wr_en            = 1'b1;
            wr_addr          = best_idx;
            wr_data          = rd_data;
            count_in         = count_ff - 1'b1;
            res_ev_in        = 1'b1;
            res_ev_handle_in = best_handle;
         end
         ST_APPEND: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[IDX_W-1:0];
            wr_data  = {key_ff, handle_ff, tick_ff};
            tick_in  = tick_ff + 1'b1;
            count_in = count_ff + 1'b1;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in     = 1'b1;
               rsp_hit_in       = res_hit_ff;
               rsp_found_in     = res_found_ff;
               rsp_ev_in        = res_ev_ff;
               rsp_ev_handle_in = res_ev_handle_ff;
               rsp_occ_in       = count_ff;
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         tick_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tick_ff      <= tick_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff           <= key_in;
      handle_ff        <= handle_in;
      addr_ff          <= addr_in;
      pend_idx_ff      <= pend_idx_in;
      res_hit_ff       <= res_hit_in;
      res_found_ff     <= res_found_in;
      res_ev_ff        <= res_ev_in;
      res_ev_handle_ff <= res_ev_handle_in;
      rsp_hit_ff       <= rsp_hit_in;
      rsp_found_ff     <= rsp_found_in;
      rsp_ev_ff        <= rsp_ev_in;
      rsp_ev_handle_ff <= rsp_ev_handle_in;
      rsp_occ_ff       <= rsp_occ_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.hit            = rsp_hit_ff;
   assign rsp_ch.found_handle   = rsp_found_ff;
   assign rsp_ch.evicted        = rsp_ev_ff;
   assign rsp_ch.evicted_handle = rsp_ev_handle_ff;
   assign rsp_ch.occupancy      = rsp_occ_ff;

endmodule

`default_nettype wire

// ----- sv/gclt_checker.sv -----
// ----------------------------------------------------------------------------
// Glyph cache port checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gclt_checker #(
   parameter int CACHE_ENTRIES = gclt_pkg::CACHE_ENTRIES_DEF,
   parameter int OCC_W         = $clog2(CACHE_ENTRIES + 1)
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_hit,
   input logic [gclt_pkg::HANDLE_W-1:0] rsp_found_handle,
   input logic                          rsp_evicted,
   input logic [gclt_pkg::HANDLE_W-1:0] rsp_evicted_handle,
   input logic [OCC_W-1:0]              rsp_occupancy
);
   import gclt_pkg::*;

   localparam logic [OCC_W-1:0] FULL_COUNT = OCC_W'(CACHE_ENTRIES);

   // a stalled result word stays valid and holds its handles and occupancy
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found_handle)
         && $stable(rsp_evicted_handle) && $stable(rsp_occupancy))
      else $error("stalled result word changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_found_handle == '0)
      else $error("found handle set without a hit");

   a_noevict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> rsp_evicted_handle == '0)
      else $error("evicted handle set without eviction");

   a_hit_xor_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_evicted))
      else $error("hit and eviction in one result");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> rsp_occupancy == FULL_COUNT)
      else $error("eviction on a table that is not full");

endmodule

bind glyph_cache_lru_table_unit gclt_checker #(
   .CACHE_ENTRIES (CACHE_ENTRIES)
) u_gclt_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_hit            (rsp_ch.hit),
   .rsp_found_handle   (rsp_ch.found_handle),
   .rsp_evicted        (rsp_ch.evicted),
   .rsp_evicted_handle (rsp_ch.evicted_handle),
   .rsp_occupancy      (rsp_ch.occupancy)
);

`default_nettype wire
